// File: design/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared constants, types and helpers for the history prefix matcher.
// ----------------------------------------------------------------------------
package hpm_pkg;

    localparam int CHAR_W       = 8;
    localparam int OUT_IDX_W    = 5;
    localparam int OUT_LEN_W    = 5;
    localparam int IDX_BITS_W   = 3;
    localparam int CFG_W        = 5;
    localparam int COUNT_MAX_W  = 5;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int M_TDATA_W    = 16;

    localparam logic [CFG_W-1:0] MIN_MATCH_RESET = 5'd3;

    // word select taken from paddr[2]
    localparam logic REG_MIN_MATCH = 1'b0;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic [OUT_LEN_W-1:0] length;
    } pick_t;

    // floor(log2(c)) + 1, zero for c == 0
    function automatic logic [IDX_BITS_W-1:0] index_bits_of(input logic [COUNT_MAX_W-1:0] c);
        logic [IDX_BITS_W-1:0] r;
        r = '0;
        for (int i = 0; i < COUNT_MAX_W; i++) begin
            if (c[i]) begin
                r = IDX_BITS_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

// File: design/history_prefix_matcher_core.sv
// ----------------------------------------------------------------------------
// history_prefix_matcher_core
// Front-coding prefix match of a byte stream against a ring of past strings.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | note
//  s_      | in  | [7:0] char_byte               | [0] new_tbl | one beat a byte
//  m_      | out | [0] found [5:1] index         | -           | one beat per
//          |     | [10:6] prefix [13:11] idxbits |             | terminator
//  apb     | in  | reg 0 at 0x0: min_match[4:0]  | -           | pready tied high
//
//  One byte per cycle while s_tready is high; the result beat appears the cycle
//  after the terminator. The next position's row is read from the history RAM
//  via pos_next into a register; all slots are compared in parallel against it.
//  Reset is synchronous; the RAM needs no clearing pass (per-slot lengths gate it).
//  s_tready drops only while a result beat is held and m_tready is low.
// ----------------------------------------------------------------------------
module history_prefix_matcher_core
    import hpm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 31,
    parameter int PREFIX_BITS   = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,   // [7:0] char_byte
    input  logic [0:0]             s_tuser,   // [0] new_table
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [0] match_found, [5:1] history_index,
                                              // [10:6] prefix_length, [13:11] index_bits
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int N          = HISTORY_DEPTH;
    localparam int PW         = PREFIX_BITS;
    localparam int MAX_PREFIX = (1 << PREFIX_BITS) - 1;
    localparam int SLOT_W     = (N > 1) ? $clog2(N) : 1;
    localparam int CNT_W      = $clog2(N + 1);

    // configuration
    logic [CFG_W-1:0] min_match_reg;
    logic             cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_ADDR_W-1] == REG_MIN_MATCH);
    assign prdata  = cfg_sel ? APB_DATA_W'(min_match_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_match_reg <= MIN_MATCH_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            min_match_reg <= pwdata[CFG_W-1:0];
        end
    end

    // state
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SLOT_W-1:0]          oldest_reg, oldest_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic [N-1:0]               still_reg, still_next;
    logic [N-1:0][PW-1:0]       mlen_reg, mlen_next;
    logic [PW-1:0]              len_reg [N];

    logic                       accept, new_tbl, is_term, cmp_en;
    logic [CHAR_W-1:0]          char_in;
    logic [CNT_W-1:0]           count_eff;
    logic [SLOT_W-1:0]          oldest_eff;
    logic [PW-1:0]              pos_eff;
    logic [SLOT_W:0]            dst_sum;
    logic [SLOT_W-1:0]          dst;
    logic [N-1:0][SLOT_W-1:0]   age;
    logic [N-1:0]               lane_valid;
    logic [N*CHAR_W-1:0]        row;

    assign accept     = s_tvalid && s_tready;
    assign char_in    = s_tdata;
    assign new_tbl    = s_tuser[0];
    assign is_term    = (char_in == '0);
    assign count_eff  = new_tbl ? '0 : count_reg;
    assign oldest_eff = new_tbl ? '0 : oldest_reg;
    assign pos_eff    = new_tbl ? '0 : pos_reg;
    assign cmp_en     = accept && !is_term && (pos_eff != PW'(MAX_PREFIX));

    assign dst_sum = (SLOT_W+1)'(oldest_eff) + (SLOT_W+1)'(count_eff);
    always_comb begin
        if ((SLOT_W+1)'(count_eff) >= (SLOT_W+1)'(N)) begin
            dst = oldest_eff;
        end else if (dst_sum >= (SLOT_W+1)'(N)) begin
            dst = SLOT_W'(dst_sum - (SLOT_W+1)'(N));
        end else begin
            dst = SLOT_W'(dst_sum);
        end
    end

    // slot age (0 = oldest) and occupancy
    for (genvar i = 0; i < N; i++) begin : g_age
        logic [SLOT_W:0] wrapped;
        assign wrapped = (SLOT_W+1)'(i + N) - (SLOT_W+1)'(oldest_eff);
        always_comb begin
            if (SLOT_W'(i) >= oldest_eff) begin
                age[i] = SLOT_W'(i) - oldest_eff;
            end else begin
                age[i] = wrapped[SLOT_W-1:0];
            end
        end
        assign lane_valid[i] = (SLOT_W+1)'(age[i]) < (SLOT_W+1)'(count_eff);
    end

    // per-slot prefix tracking
    always_comb begin
        logic [CHAR_W-1:0] e;
        still_next = still_reg;
        mlen_next  = mlen_reg;
        for (int i = 0; i < N; i++) begin
            e = (pos_eff < len_reg[i]) ? row[i*CHAR_W +: CHAR_W] : '0;
            if (accept && (is_term || new_tbl)) begin
                still_next[i] = 1'b1;
                mlen_next[i]  = '0;
            end
            if (cmp_en && lane_valid[i] && still_next[i]) begin
                if (e == char_in) begin
                    mlen_next[i] = mlen_next[i] + PW'(1);
                end else begin
                    still_next[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        pos_next    = pos_reg;
        if (accept) begin
            count_next  = count_eff;
            oldest_next = oldest_eff;
            pos_next    = pos_eff;
            if (is_term) begin
                pos_next = '0;
                if ((SLOT_W+1)'(count_eff) >= (SLOT_W+1)'(N)) begin
                    oldest_next = (oldest_eff == SLOT_W'(N - 1)) ? '0 : oldest_eff + SLOT_W'(1);
                end else begin
                    count_next = count_eff + CNT_W'(1);
                end
            end else if (cmp_en) begin
                pos_next = pos_eff + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            oldest_reg <= '0;
            pos_reg    <= '0;
            still_reg  <= '1;
            mlen_reg   <= '0;
        end else begin
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            pos_reg    <= pos_next;
            still_reg  <= still_next;
            mlen_reg   <= mlen_next;
        end
    end

    // stored length of each slot; bytes beyond it read as zero
    always_ff @(posedge aclk) begin
        if (accept && is_term) begin
            len_reg[dst] <= pos_eff;
        end
    end

    hpm_hist_ram #(
        .LANES  (N),
        .LANE_W (SLOT_W),
        .ADDR_W (PW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmp_en),
        .wr_addr (pos_eff),
        .wr_lane (dst),
        .wr_data (char_in),
        .rd_addr (pos_next),
        .rd_data (row)
    );

    // result
    pick_t                  pick;
    pick_t                  res_reg;
    logic [IDX_BITS_W-1:0]  idx_bits_reg;
    logic                   m_valid_reg;

    hpm_best_select #(
        .N      (N),
        .PW     (PW),
        .SLOT_W (SLOT_W)
    ) u_sel (
        .mlen       (mlen_reg),
        .age        (age),
        .lane_valid (lane_valid),
        .min_match  (min_match_reg),
        .pick       (pick)
    );

    assign s_tready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && is_term) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_term) begin
            res_reg      <= pick;
            idx_bits_reg <= pick.found ? index_bits_of(COUNT_MAX_W'(count_eff)) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - IDX_BITS_W - OUT_LEN_W - OUT_IDX_W - 1)'(0),
                       idx_bits_reg, res_reg.length, res_reg.index, res_reg.found};

    // checks
    a_term_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_term |=> m_tvalid)
        else $error("terminator accepted without result beat");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_term && !new_tbl && (pos_reg != PW'(MAX_PREFIX))
        |=> pos_reg == $past(pos_reg) + PW'(1))
        else $error("character position did not advance");

    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_term && !new_tbl && ((SLOT_W+1)'(count_reg) < (SLOT_W+1)'(N))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("history count did not grow on append");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (SLOT_W+1)'(count_reg) <= (SLOT_W+1)'(N))
        else $error("history count beyond depth");

endmodule

// File: design/hpm_hist_ram.sv
// ----------------------------------------------------------------------------
// hpm_hist_ram
// History store: one row per character position, one byte lane per slot.
// Byte-lane write, registered row read.
// ----------------------------------------------------------------------------
module hpm_hist_ram
    import hpm_pkg::*;
#(
    parameter int LANES  = 31,
    parameter int LANE_W = 5,
    parameter int ADDR_W = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [LANE_W-1:0]        wr_lane,
    input  logic [CHAR_W-1:0]        wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [LANES*CHAR_W-1:0]  rd_data
);

    logic [LANES*CHAR_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][wr_lane*CHAR_W +: CHAR_W] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/hpm_best_select.sv
// ----------------------------------------------------------------------------
// hpm_best_select
// Picks the longest eligible prefix over all slots; oldest wins a tie.
// Balanced compare tree on {eligible, length, ~age}.
// ----------------------------------------------------------------------------
module hpm_best_select
    import hpm_pkg::*;
#(
    parameter int N      = 31,
    parameter int PW     = 5,
    parameter int SLOT_W = 5
) (
    input  logic [N-1:0][PW-1:0]     mlen,
    input  logic [N-1:0][SLOT_W-1:0] age,
    input  logic [N-1:0]             lane_valid,
    input  logic [CFG_W-1:0]         min_match,
    output pick_t                    pick
);

    localparam int LVLS  = (N > 1) ? $clog2(N) : 0;
    localparam int NP    = 1 << LVLS;
    localparam int KEY_W = 1 + PW + SLOT_W;
    localparam int CW    = (PW > CFG_W) ? PW : CFG_W;

    logic [KEY_W-1:0] node [2*NP-1];
    logic [KEY_W-1:0] best;

    for (genvar i = 0; i < NP; i++) begin : g_leaf
        if (i < N) begin : g_real
            logic elig;
            assign elig = lane_valid[i] && (mlen[i] != '0)
                          && (CW'(mlen[i]) >= CW'(min_match));
            assign node[NP-1+i] = {elig, mlen[i], ~age[i]};
        end else begin : g_pad
            assign node[NP-1+i] = '0;
        end
    end

    for (genvar k = 0; k < NP - 1; k++) begin : g_node
        assign node[k] = (node[2*k+1] >= node[2*k+2]) ? node[2*k+1] : node[2*k+2];
    end

    assign best         = node[0];
    assign pick.found   = best[KEY_W-1];
    assign pick.length  = best[KEY_W-1] ? OUT_LEN_W'(best[PW+SLOT_W-1:SLOT_W]) : '0;
    assign pick.index   = best[KEY_W-1] ? OUT_IDX_W'(~best[SLOT_W-1:0]) : '0;

endmodule
